### src/pdse_pkg.sv
// Shared constants and types for the pixel digit hidden-data extractor.
`default_nettype none

package pdse_pkg;

   // Pixel channel and result widths
   localparam int CHANNEL_W = 8;
   localparam int BYTE_W    = 8;
   localparam int CHANNELS  = 3;

   // Payload length in bytes and payload bit count
   localparam int LEN_W  = 9;
   localparam int BITS_W = 12;

   // Default header length in pixels
   localparam int HEADER_PIXELS_DEF = 3;

   // Decimal digit extraction: value / 10 as (value * 205) >> 11, exact below 1029
   localparam int DIGIT_BASE   = 10;
   localparam int RECIP_MUL    = 205;
   localparam int RECIP_SHIFT  = 11;
   localparam int PROD_W       = 16;
   localparam int QUOT_W       = 5;
   localparam int HIDDEN_DIGIT = 1;

   typedef logic [CHANNEL_W-1:0] channel_type;
   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [LEN_W-1:0]     length_type;
   typedef logic [BITS_W-1:0]    bit_count_type;

endpackage

`default_nettype wire

### src/pdse_digit_bit.sv
// Last decimal digit of one channel value, turned into a hidden bit.
`default_nettype none

module pdse_digit_bit (
   input  wire pdse_pkg::channel_type value,
   output logic                       hidden_bit
);
   import pdse_pkg::*;

   logic [PROD_W-1:0]    product;
   logic [QUOT_W-1:0]    quotient;
   logic [CHANNEL_W-1:0] tens;
   logic [CHANNEL_W-1:0] digit;

   // value mod 10 via reciprocal multiply; quotient never exceeds 25
   assign product    = PROD_W'(value) * PROD_W'(RECIP_MUL);
   assign quotient   = QUOT_W'(product >> RECIP_SHIFT);
   assign tens       = CHANNEL_W'(quotient) * CHANNEL_W'(DIGIT_BASE);
   assign digit      = value - tens;

   // only a digit of one is a hidden one
   assign hidden_bit = (digit == CHANNEL_W'(HIDDEN_DIGIT));

endmodule

`default_nettype wire

### src/pixel_digit_stego_extractor.sv
// Top level: pixel digit hidden-data extractor with input and result registers.
//
// Usage
//   Request channel: one RGB pixel per request (req_red, req_green, req_blue,
//   req_start_of_image), taken on a clock edge with req_valid high and
//   req_stall low. req_start_of_image clears the decoder before its pixel.
//   Result channel: rsp_data_byte and rsp_last_byte, handed over on an edge
//   with rsp_valid high and rsp_stall low. A pixel yields zero or one byte.
//   The first HEADER_PIXELS pixels of an image carry the payload length in
//   bytes (three bits per pixel, MSB first); later channels carry payload
//   bits, LSB first in each byte. After the last byte, pixels are dropped
//   until the next start of image.
// Timing
//   Path: an accepted pixel goes into the input register, then is decoded into
//   the result register; it waits in the input register while a byte is stuck.
//   Throughput: one pixel per cycle while the receiver does not stall; the decode
//   of a pixel's three digits and the byte packing are combinational logic.
// Reset and stall
//   Synchronous reset empties both registers and clears the decoder. While the
//   receiver stalls, pixels flow until a byte waits in the result register;
//   one more pixel is then held in the input register and req_stall rises.
`default_nettype none

module pixel_digit_stego_extractor #(
   parameter int HEADER_PIXELS = pdse_pkg::HEADER_PIXELS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   // request channel
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire pdse_pkg::channel_type req_red,
   input  wire pdse_pkg::channel_type req_green,
   input  wire pdse_pkg::channel_type req_blue,
   input  wire                        req_start_of_image,
   // result channel
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output pdse_pkg::byte_type         rsp_data_byte,
   output logic                       rsp_last_byte
);
   import pdse_pkg::*;

   localparam int HS_W = $clog2(HEADER_PIXELS + 1);

   // input register
   logic        in_valid_ff;
   channel_type in_red_ff, in_green_ff, in_blue_ff;
   logic        in_start_ff;

   // decoder state
   logic [HS_W-1:0] hdr_seen_ff,  hdr_seen_in;
   length_type      length_ff,    length_in;
   bit_count_type   bits_ff,      bits_in;
   byte_type        acc_ff,       acc_in;

   // result register
   logic     rsp_valid_ff;
   byte_type rsp_byte_ff, rsp_byte_in;
   logic     rsp_last_ff, rsp_last_in;
   logic     emit_in;

   logic                consume;
   logic [CHANNELS-1:0] hidden;

   // the held request moves on unless a result is stuck at the output
   assign consume   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !consume;

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_red_ff   <= req_red;
         in_green_ff <= req_green;
         in_blue_ff  <= req_blue;
         in_start_ff <= req_start_of_image;
      end
   end

   // hidden bits, red first
   pdse_digit_bit u_red   (.value(in_red_ff),   .hidden_bit(hidden[0]));
   pdse_digit_bit u_green (.value(in_green_ff), .hidden_bit(hidden[1]));
   pdse_digit_bit u_blue  (.value(in_blue_ff),  .hidden_bit(hidden[2]));

   // header shift and payload packing for one pixel
   always_comb begin
      logic [HS_W-1:0] hs_v;
      length_type      len_v;
      bit_count_type   bt_v;
      bit_count_type   total_v;
      byte_type        acc_v;
      hs_v        = hdr_seen_ff;
      len_v       = length_ff;
      bt_v        = bits_ff;
      acc_v       = acc_ff;
      emit_in     = 1'b0;
      rsp_byte_in = '0;
      rsp_last_in = 1'b0;
      if (in_start_ff) begin
         hs_v  = '0;
         len_v = '0;
         bt_v  = '0;
         acc_v = '0;
      end
      total_v = {len_v, 3'b000};
      if (hs_v < HS_W'(HEADER_PIXELS)) begin
         len_v = {len_v[LEN_W-4:0], hidden[0], hidden[1], hidden[2]};
         hs_v  = hs_v + HS_W'(1);
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (bt_v < total_v) begin
               acc_v = acc_v | (BYTE_W'(hidden[c]) << bt_v[2:0]);
               bt_v  = bt_v + BITS_W'(1);
               if (bt_v[2:0] == 3'd0) begin
                  emit_in     = 1'b1;
                  rsp_byte_in = acc_v;
                  rsp_last_in = (bt_v == total_v);
                  acc_v       = '0;
               end
            end
         end
      end
      hdr_seen_in = hs_v;
      length_in   = len_v;
      bits_in     = bt_v;
      acc_in      = acc_v;
   end

   // decoder state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_seen_ff  <= '0;
         length_ff    <= '0;
         bits_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (consume) begin
         hdr_seen_ff  <= hdr_seen_in;
         length_ff    <= length_in;
         bits_ff      <= bits_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= emit_in;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (consume && emit_in) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the pixel digit hidden-data extractor.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pdse_pkg::*;

   localparam int HDR_PIXELS   = HEADER_PIXELS_DEF;
   localparam int HDR_BITS     = CHANNELS * HDR_PIXELS;
   localparam int PIXEL_TARGET = 1050;
   localparam int STALE_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 250;
   localparam int IDLE_PCT     = 33;

   typedef struct packed {
      channel_type red;
      channel_type green;
      channel_type blue;
      logic        sop;
   } pixel_type;

   typedef struct packed {
      byte_type data;
      logic     last;
   } byte_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   channel_type req_red = '0;
   channel_type req_green = '0;
   channel_type req_blue = '0;
   logic        req_start_of_image = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   byte_type    rsp_data_byte;
   logic        rsp_last_byte;

   pixel_type       pending_pixels[$];
   byte_result_type expected_bytes[$];

   // decoder copy used for prediction
   int            hdr_seen;
   length_type    pay_len;
   bit_count_type bits_used;
   byte_type      acc_byte;

   int errors;
   int bytes_seen;
   int counted_pixels;
   int cycle_cnt;
   int stale_cycles;
   int hold_left;
   bit hold_done;

   pixel_digit_stego_extractor uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_start_of_image (req_start_of_image),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last_byte      (rsp_last_byte)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // a digit of one hides a 1, anything else a 0
   function automatic bit hidden_bit(channel_type v);
      return (v % DIGIT_BASE) == HIDDEN_DIGIT;
   endfunction

   // random idling, switched off for one stretch of the run
   function automatic bit take_break();
      int pct;
      pct = (cycle_cnt >= 600 && cycle_cnt < 1100) ? 0 : IDLE_PCT;
      return $urandom_range(0, 99) < pct;
   endfunction

   // predict the byte (if any) that one accepted pixel completes
   task automatic decode_pixel(pixel_type px);
      bit [CHANNELS-1:0] hid;
      bit_count_type     total;
      byte_result_type   res;
      hid[0] = hidden_bit(px.red);
      hid[1] = hidden_bit(px.green);
      hid[2] = hidden_bit(px.blue);
      if (px.sop) begin
         hdr_seen  = 0;
         pay_len   = '0;
         bits_used = '0;
         acc_byte  = '0;
      end
      if (hdr_seen < HDR_PIXELS) begin
         for (int c = 0; c < CHANNELS; c++)
            pay_len = {pay_len[LEN_W-2:0], hid[c]};
         hdr_seen++;
         return;
      end
      total = bit_count_type'(pay_len) << 3;
      for (int c = 0; c < CHANNELS; c++) begin
         if (bits_used >= total)
            break;
         acc_byte[bits_used[2:0]] = acc_byte[bits_used[2:0]] | hid[c];
         bits_used = bits_used + 1'b1;
         if (bits_used[2:0] == 3'd0) begin
            res.data = acc_byte;
            res.last = (bits_used == total);
            expected_bytes = {expected_bytes, res};
            acc_byte = '0;
         end
      end
   endtask

   task automatic add_pixel(int r, int g, int b, bit s);
      pixel_type px;
      px.red   = channel_type'(r);
      px.green = channel_type'(g);
      px.blue  = channel_type'(b);
      px.sop   = s;
      pending_pixels = {pending_pixels, px};
      counted_pixels++;
   endtask

   // channel value whose last decimal digit carries the wanted bit
   function automatic channel_type encode_bit(bit hb);
      channel_type v;
      if (hb)
         return channel_type'(DIGIT_BASE * $urandom_range(0, 25) + HIDDEN_DIGIT);
      do
         v = channel_type'($urandom_range(0, 255));
      while (v % DIGIT_BASE == HIDDEN_DIGIT);
      return v;
   endfunction

   // one image: header with the length, payload pixels, some trailing pixels
   task automatic add_image(int len, bit cut_short, int trailing);
      int nbits;
      int npix;
      int idx;
      channel_type ch[CHANNELS];
      for (int p = 0; p < HDR_PIXELS; p++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            idx = HDR_BITS - 1 - (p * CHANNELS + c);
            ch[c] = encode_bit(idx < LEN_W ? len[idx] : 1'b0);
         end
         add_pixel(ch[0], ch[1], ch[2], p == 0);
      end
      nbits = len * 8;
      npix  = (nbits + CHANNELS - 1) / CHANNELS;
      if (cut_short && npix > 0)
         npix = $urandom_range(0, npix - 1);
      for (int p = 0; p < npix; p++) begin
         for (int c = 0; c < CHANNELS; c++)
            ch[c] = encode_bit($urandom_range(0, 1));
         add_pixel(ch[0], ch[1], ch[2], 1'b0);
      end
      for (int p = 0; p < trailing; p++)
         add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 255), 1'b0);
   endtask

   // request driver
   always @(posedge clock) begin : drive_pixels
      pixel_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            decode_pixel('{req_red, req_green, req_blue, req_start_of_image});
         if (!req_valid || !req_stall) begin
            if (pending_pixels.size() != 0 && !take_break()) begin
               px = pending_pixels.pop_front();
               req_valid          <= 1'b1;
               req_red            <= px.red;
               req_green          <= px.green;
               req_blue           <= px.blue;
               req_start_of_image <= px.sop;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin : check_bytes
      byte_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected byte: expected none, actual data %h last %b",
                        $time, rsp_data_byte, rsp_last_byte);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data_byte !== want.data) begin
                  errors++;
                  $display("%0t: data_byte mismatch: expected %h, actual %h",
                           $time, want.data, rsp_data_byte);
               end
               if (rsp_last_byte !== want.last) begin
                  errors++;
                  $display("%0t: last_byte mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last_byte);
               end
            end
         end
         // one long hold-off so the block backs up into the request side
         if (!hold_done && bytes_seen >= 30) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= take_break();
         end
      end
   end

   // cycle count and progress watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stale_cycles <= 0;
      else
         stale_cycles <= stale_cycles + 1;
   end

   initial begin : watchdog
      wait (stale_cycles >= STALE_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin : sequencer
      int len;
      int roll;
      errors         = 0;
      bytes_seen     = 0;
      counted_pixels = 0;
      cycle_cnt      = 0;
      stale_cycles   = 0;
      hold_left      = 0;
      hold_done      = 1'b0;
      hdr_seen       = 0;
      pay_len        = '0;
      bits_used      = '0;
      acc_byte       = '0;

      // no start mark: header decoded straight after reset, length one
      add_pixel(255, 0, 128, 1'b0);
      add_pixel(99, 200, 10, 1'b0);
      add_pixel(64, 7, 241, 1'b0);
      add_pixel(1, 11, 21, 1'b0);
      add_pixel(250, 31, 2, 1'b0);
      add_pixel(91, 3, 201, 1'b0);   // blue is past the payload end
      // zero length, following pixel ignored
      add_pixel(0, 0, 0, 1'b1);
      add_pixel(0, 0, 0, 1'b0);
      add_pixel(0, 0, 0, 1'b0);
      add_pixel(1, 1, 1, 1'b0);
      // maximum length, then restarted mid payload
      add_pixel(1, 11, 21, 1'b1);
      add_pixel(31, 41, 51, 1'b0);
      add_pixel(61, 71, 81, 1'b0);
      add_pixel(101, 111, 121, 1'b0);
      add_pixel(131, 141, 151, 1'b0);
      add_pixel(161, 171, 181, 1'b0);
      // start mark inside a header restarts it; length two
      add_pixel(241, 251, 0, 1'b1);
      add_pixel(0, 0, 0, 1'b1);
      add_pixel(0, 0, 0, 1'b0);
      add_pixel(0, 1, 0, 1'b0);
      add_pixel(255, 1, 128, 1'b0);
      add_pixel(11, 254, 77, 1'b0);
      add_pixel(0, 221, 1, 1'b0);
      add_pixel(245, 191, 50, 1'b0);
      add_pixel(81, 0, 19, 1'b0);
      add_pixel(1, 250, 211, 1'b0);

      // random images, mostly well formed, some cut short, some noise
      while (counted_pixels < PIXEL_TARGET) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) begin
            if ($urandom_range(0, 11) == 0)
               len = $urandom_range(11, 80);
            else
               len = $urandom_range(0, 10);
            add_image(len, $urandom_range(0, 7) == 0, $urandom_range(0, 3));
         end else begin
            repeat ($urandom_range(1, 6))
               add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 3) == 0);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for everything sent and every predicted byte received
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && expected_bytes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
